// File: design/cpl_pkg.sv
`timescale 1ns / 1ps
package cpl_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 32;

  // command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_LIST = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_ADDED     = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_DELETED   = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_ENTRY     = 3'd4;
  localparam logic [2:0] KIND_EMPTY     = 3'd5;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [ID_W-1:0] process_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic signed [ID_W-1:0] process_id_out;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_MV,
    S_DEL_RD,
    S_DEL_CMP,
    S_SH_RD,
    S_SH_WR,
    S_LST_RD,
    S_LST_OUT,
    S_RESP
  } state_e;

endpackage

// File: design/cpl_mem.sv
`timescale 1ns / 1ps
module cpl_mem (
  input  logic                     clk_i,
  input  cpl_pkg::mem_req_t        req_i,
  output logic [cpl_pkg::ID_W-1:0] rdata_o
);
  import cpl_pkg::*;

  logic [ID_W-1:0] mem [CAPACITY];
  logic [ID_W-1:0] rdata_q;

  // read returns the old word when the same address is written
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cpl_seq.sv
`timescale 1ns / 1ps
module cpl_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  cpl_pkg::in_item_t        in_data_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output cpl_pkg::out_item_t       res_data_o,
  output cpl_pkg::mem_req_t        mem_req_o,
  input  logic [cpl_pkg::ID_W-1:0] mem_rdata_i
);
  import cpl_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [2:0]       kind_q, kind_d;

  logic [IDX_W-1:0] idx_p1;
  logic [IDX_W-1:0] idx_p2;
  logic             at_last;
  logic             more;
  logic             hit;

  assign idx_p1  = idx_q + IDX_W'(1);
  assign idx_p2  = idx_q + IDX_W'(2);
  assign at_last = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));
  assign more    = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(2)) < (CNT_W+1)'(count_q);
  // the one shared comparator: stored word against the searched ID
  assign hit     = (mem_rdata_i == id_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.cmd)
            CMD_ADD:  state_d = (count_q == CNT_W'(CAPACITY)) ? S_RESP : S_ADD_RD;
            CMD_DEL:  state_d = (count_q == '0) ? S_RESP : S_DEL_RD;
            CMD_LIST: state_d = (count_q == '0) ? S_RESP : S_LST_RD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_RD:  state_d = (count_q == '0) ? S_RESP : S_ADD_MV;
      S_ADD_MV:  state_d = S_RESP;
      S_DEL_RD:  state_d = S_DEL_CMP;
      S_DEL_CMP: begin
        if (hit) begin
          state_d = S_SH_RD;
        end else if (at_last) begin
          state_d = S_RESP;
        end
      end
      S_SH_RD:   state_d = at_last ? S_RESP : S_SH_WR;
      S_SH_WR:   state_d = more ? S_SH_WR : S_RESP;
      S_LST_RD:  state_d = S_LST_OUT;
      S_LST_OUT: begin
        if (res_ready_i && at_last) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    id_d        = id_q;
    kind_d      = kind_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_data_o  = '{kind: kind_q,
                    process_id_out: (kind_q == KIND_EMPTY) ? '0 : id_q,
                    last: 1'b1};
    mem_req_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          id_d  = in_data_i.process_id;
          idx_d = '0;
          case (in_data_i.cmd)
            CMD_ADD:  kind_d = KIND_FULL;
            CMD_DEL:  kind_d = KIND_NOT_FOUND;
            default:  kind_d = KIND_EMPTY;
          endcase
        end
      end
      S_ADD_RD: begin
        // write the new head and fetch the old one in the same cycle
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = '0;
        mem_req_o.wdata = id_q;
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = '0;
        if (count_q == '0) begin
          count_d = count_q + CNT_W'(1);
          kind_d  = KIND_ADDED;
        end
      end
      S_ADD_MV: begin
        // old head goes to the tail
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = count_q[IDX_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        count_d         = count_q + CNT_W'(1);
        kind_d          = KIND_ADDED;
      end
      S_DEL_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = idx_q;
      end
      S_DEL_CMP: begin
        if (hit) begin
          kind_d = KIND_DELETED;
        end else if (!at_last) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_p1;
          idx_d           = idx_p1;
        end
      end
      S_SH_RD: begin
        if (at_last) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_p1;
        end
      end
      S_SH_WR: begin
        // close the gap: entry idx takes its successor, fetch the next one
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = mem_rdata_i;
        if (more) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_p2;
          idx_d           = idx_p1;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      S_LST_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = idx_q;
      end
      S_LST_OUT: begin
        res_valid_o = 1'b1;
        res_data_o  = '{kind: KIND_ENTRY, process_id_out: mem_rdata_i, last: at_last};
        // hold the read word until it is taken
        if (res_ready_i && !at_last) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_p1;
          idx_d           = idx_p1;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    kind_q <= kind_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) ||
    (count_q + CNT_W'(1) == $past(count_q)))
    else $error("entry count moved by more than one");

  a_list_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LST_OUT) |-> (CNT_W'(idx_q) < count_q))
    else $error("list walk past the last entry");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESP || state_q == S_LST_OUT) |-> !mem_req_o.we)
    else $error("memory write outside an update sequence");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q) == S_IDLE) |-> $stable(count_q))
    else $error("entry count changed while idle");

endmodule

// File: design/circular_process_list_core.sv
`timescale 1ns / 1ps
// Ring of up to 32 process IDs, head first, held in a single-port-write memory.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one command word:
// add, delete by ID or list. Output channel (out_valid_o / out_ready_i /
// out_data_o) returns result words; the final word of each command has last set.
// Commands are taken one at a time; in_ready_o is high only when the sequencer
// is idle. Command code 3 is consumed without a result.
// Steps from acceptance to the result entering the output register:
//   add:    write the new head and read the old one, then move the old head
//           to the tail; an empty list skips the move, a full list is refused
//   delete: read and compare the entries in order; on a match, the entries
//           behind it move down one place; an empty list is answered directly
//   list:   read the entries in order, one word per cycle while the output
//           register takes them, count words in all; an empty list gives the
//           empty word
// The memory read port, with its registered read data, paces these steps.
// The output register keeps a finished word while the receiver stalls; the
// sequencer holds in place (and a list walk pauses) until the word is taken.
// Reset empties the list at once; no clearing pass is needed, since memory
// words are only read below the entry count.
module circular_process_list_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cpl_pkg::out_item_t out_data_o
);
  import cpl_pkg::*;

  logic            res_valid;
  logic            res_ready;
  out_item_t       res_data;
  mem_req_t        mem_req;
  logic [ID_W-1:0] mem_rdata;

  logic            out_valid_q;
  out_item_t       out_data_q;

  cpl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  cpl_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: dv/cpl_list_checker.sv
`timescale 1ns / 1ps
module cpl_list_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  cpl_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  cpl_pkg::out_item_t out_data_i,
  input  logic               end_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import cpl_pkg::*;

  // Shadow copy of the ring, head at index 0
  logic [ID_W-1:0] ring_ids [CAPACITY];
  int unsigned     ring_len;
  out_item_t       expected_words [$];
  out_item_t       want;
  bit              end_seen;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic queue_result(input logic [2:0] kind, input logic [ID_W-1:0] id,
                              input logic last);
    out_item_t w;
    w.kind           = kind;
    w.process_id_out = id;
    w.last           = last;
    expected_words.push_back(w);
  endtask

  // Update the shadow ring for one command word and queue the words it returns
  task automatic apply_command(input in_item_t w);
    logic [ID_W-1:0] id;
    int unsigned     hit;
    int unsigned     k;
    id = w.process_id;
    case (w.cmd)
      CMD_ADD: begin
        if (ring_len >= CAPACITY) begin
          queue_result(KIND_FULL, id, 1'b1);
        end else begin
          // old head moves to the tail, new ID takes the head
          if (ring_len != 0) ring_ids[ring_len] = ring_ids[0];
          ring_ids[0] = id;
          ring_len++;
          queue_result(KIND_ADDED, id, 1'b1);
        end
      end
      CMD_DEL: begin
        hit = 0;
        while (hit < ring_len && ring_ids[hit] != id) hit++;
        if (hit == ring_len) begin
          queue_result(KIND_NOT_FOUND, id, 1'b1);
        end else begin
          for (k = hit; k + 1 < ring_len; k++) ring_ids[k] = ring_ids[k + 1];
          ring_len--;
          queue_result(KIND_DELETED, id, 1'b1);
        end
      end
      CMD_LIST: begin
        if (ring_len == 0) begin
          queue_result(KIND_EMPTY, '0, 1'b1);
        end else begin
          for (k = 0; k < ring_len; k++) queue_result(KIND_ENTRY, ring_ids[k], k + 1 == ring_len);
        end
      end
      default: begin
        // unused code: consumed without a result
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_len = 0;
      expected_words.delete();
      end_seen = 1'b0;
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d id %h last %b",
                                    out_data_i.kind, out_data_i.process_id_out,
                                    out_data_i.last));
        end else begin
          want = expected_words.pop_front();
          if (out_data_i.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_data_i.kind, want.kind));
          if (out_data_i.process_id_out !== want.process_id_out)
            report_mismatch($sformatf("id %h, want %h", out_data_i.process_id_out,
                                      want.process_id_out));
          if (out_data_i.last !== want.last)
            report_mismatch($sformatf("last %b, want %b (id %h)", out_data_i.last,
                                      want.last, want.process_id_out));
        end
      end
      if (in_valid_i && in_ready_i) apply_command(in_data_i);
      if (end_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_words.size() != 0)
          report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

// File: dv/tb_circular_process_list_core.sv
`timescale 1ns / 1ps
module tb_circular_process_list_core;
  import cpl_pkg::*;

  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_WORDS = 470;
  localparam int unsigned ID_POOL_SIZE = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        run_end;
  bit          quiet;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned n_words;

  // small pool so deletes hit and duplicates occur
  logic [ID_W-1:0] id_pool [ID_POOL_SIZE];

  circular_process_list_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  cpl_list_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .end_i       (run_end),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(12_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 35);
  end

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(ID_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [ID_W-1:0] id);
    in_item_t w;
    w.cmd        = cmd;
    w.process_id = id;
    if (!quiet && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold until every queued result word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned roll;
    int unsigned phase;
    logic [1:0]  cmd;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    quiet       = 1'b0;
    run_end     = 1'b0;
    id_pool[0] = 32'h8000_0000;
    id_pool[1] = 32'h7fff_ffff;
    id_pool[2] = 32'h0000_0000;
    id_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < ID_POOL_SIZE; i++) id_pool[i] = $urandom;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, first add, duplicates, head / middle / tail deletes
    send_word(CMD_LIST, 32'h0000_0005);
    send_word(CMD_DEL, 32'h0000_0005);
    send_word(CMD_ADD, 32'h8000_0000);
    send_word(CMD_LIST, 32'hffff_ffff);
    send_word(CMD_ADD, 32'h7fff_ffff);
    send_word(CMD_ADD, 32'h0000_0000);
    send_word(CMD_ADD, 32'hffff_ffff);
    send_word(CMD_ADD, 32'hffff_ffff);
    send_word(CMD_LIST, 32'h0000_0000);
    send_word(CMD_DEL, 32'h0000_1234);
    send_word(CMD_UNUSED, 32'hffff_ffff);
    send_word(CMD_DEL, 32'hffff_ffff);
    send_word(CMD_LIST, 32'h0000_0000);
    send_word(CMD_DEL, 32'h0000_0000);
    send_word(CMD_DEL, 32'hffff_ffff);
    send_word(CMD_LIST, 32'h0000_0000);
    send_word(CMD_UNUSED, 32'h0000_0000);
    send_word(CMD_DEL, 32'h8000_0000);
    send_word(CMD_DEL, 32'h7fff_ffff);
    send_word(CMD_LIST, 32'h0000_0000);
    wait_drained();

    // grow with mostly adds, then mixed traffic, then shrink with mostly deletes; repeat
    n_words = 0;
    while (n_words < RANDOM_WORDS) begin
      quiet <= (n_words >= 200 && n_words < 300);
      roll  = $urandom_range(99);
      phase = (n_words / 60) % 3;
      if (roll < 2) cmd = CMD_UNUSED;
      else if (phase == 0) cmd = roll < 85 ? CMD_ADD : (roll < 95 ? CMD_DEL : CMD_LIST);
      else if (phase == 1) cmd = roll < 45 ? CMD_ADD : (roll < 80 ? CMD_DEL : CMD_LIST);
      else cmd = roll < 15 ? CMD_ADD : (roll < 88 ? CMD_DEL : CMD_LIST);
      send_word(cmd, pick_id());
      if (cmd != CMD_UNUSED) begin
        n_words++;
        if (n_words % 97 == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    run_end <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: circular_process_list_core.f
design/cpl_pkg.sv
design/cpl_mem.sv
design/cpl_seq.sv
design/circular_process_list_core.sv
dv/cpl_list_checker.sv
dv/tb_circular_process_list_core.sv
